>>> design/cpu_6502_execute_unit_assert.svh
// Assertion macros used by the execute unit module.
`ifndef CPU_6502_EXECUTE_UNIT_ASSERT_SVH
`define CPU_6502_EXECUTE_UNIT_ASSERT_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/c6502_pkg.sv
package c6502_pkg;

    typedef enum logic [5:0] {
        F_ADC = 6'd0,  F_AND = 6'd1,  F_ASL = 6'd2,  F_BCC = 6'd3,  F_BCS = 6'd4,
        F_BEQ = 6'd5,  F_BIT = 6'd6,  F_BMI = 6'd7,  F_BNE = 6'd8,  F_BPL = 6'd9,
        F_BRK = 6'd10, F_BVC = 6'd11, F_BVS = 6'd12, F_CLC = 6'd13, F_CLD = 6'd14,
        F_CLI = 6'd15, F_CLV = 6'd16, F_CMP = 6'd17, F_CPX = 6'd18, F_CPY = 6'd19,
        F_DEC = 6'd20, F_DEX = 6'd21, F_DEY = 6'd22, F_EOR = 6'd23, F_INC = 6'd24,
        F_INX = 6'd25, F_INY = 6'd26, F_JMP = 6'd27, F_JSR = 6'd28, F_LDA = 6'd29,
        F_LDX = 6'd30, F_LDY = 6'd31, F_LSR = 6'd32, F_NOP = 6'd33, F_ORA = 6'd34,
        F_PHA = 6'd35, F_PHP = 6'd36, F_PLA = 6'd37, F_PLP = 6'd38, F_ROL = 6'd39,
        F_ROR = 6'd40, F_RTI = 6'd41, F_RTS = 6'd42, F_SBC = 6'd43, F_SEC = 6'd44,
        F_SED = 6'd45, F_SEI = 6'd46, F_STA = 6'd47, F_STX = 6'd48, F_STY = 6'd49,
        F_TAX = 6'd50, F_TAY = 6'd51, F_TSX = 6'd52, F_TXA = 6'd53, F_TXS = 6'd54,
        F_TYA = 6'd55
    } func_t;

    localparam logic [1:0] CLS_OTHER = 2'd0;
    localparam logic [1:0] CLS_ACC   = 2'd1;
    localparam logic [1:0] CLS_ABSX  = 2'd2;
    localparam logic [1:0] CLS_INDY  = 2'd3;

    localparam int FL_C = 0;
    localparam int FL_Z = 1;
    localparam int FL_I = 2;
    localparam int FL_D = 3;
    localparam int FL_B = 4;
    localparam int FL_U = 5;
    localparam int FL_V = 6;
    localparam int FL_N = 7;

    localparam logic [7:0] SP_RESET   = 8'hFF;
    localparam logic [7:0] FLAG_RESET = 8'h24;
    localparam logic [7:0] STACK_PAGE = 8'h01;

    // Decoded input beat, listed from the highest bits down so that func
    // sits in the lowest bits, as on the stream.
    typedef struct packed {
        logic [15:0] break_vector;
        logic [7:0]  stack_byte_third;
        logic [7:0]  stack_byte_second;
        logic [7:0]  stack_byte_first;
        logic [15:0] pc_after_fetch;
        logic [7:0]  operand_value;
        logic [15:0] operand_address;
        logic [2:0]  base_cycles;
        logic        page_crossed;
        logic [1:0]  addressing_class;
        logic [5:0]  func;
    } instr_t;

    // Architectural registers.
    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] flags;
    } regs_t;

    // One executed instruction: up to three writes plus the common result.
    typedef struct packed {
        logic [1:0]  wr_count;
        logic [2:0][15:0] wr_addr;
        logic [2:0][7:0]  wr_data;
        regs_t       regs;
        logic [15:0] next_pc;
        logic [3:0]  cycles;
    } exec_t;

endpackage

>>> design/cpu_6502_execute_unit.sv
// Channel | Dir | tdata fields (low bit first)                      | tuser
// s_      | in  | func..break_vector, 92 bits, padded to 96          | -
// m_      | out | write_address, write_data, acc..flags, next_pc,    | write_valid
//         |     | cycles_taken (84 bits, padded to 88)               |
// An instruction is taken into the result register in the cycle it is accepted
// and one beat per memory write leaves, or a single beat with no write, so two
// beats leave for JSR and three for BRK; the write count sets that figure.
// aresetn is synchronous and active low; it sets A, X, Y to 0, SP to 0xFF and
// status to 0x24. A stalled m_ side holds the beat; s_tready stays high while
// the last beat of the held instruction is leaving.
module cpu_6502_execute_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // func[5:0], addressing_class[7:6], page_crossed[8], base_cycles[11:9],
    // operand_address[27:12], operand_value[35:28], pc_after_fetch[51:36],
    // stack_byte_first[59:52], stack_byte_second[67:60],
    // stack_byte_third[75:68], break_vector[91:76], zero fill above
    input  logic [95:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // write_address[15:0], write_data[23:16], acc_out[31:24], x_out[39:32],
    // y_out[47:40], sp_out[55:48], flags_out[63:56], next_pc[79:64],
    // cycles_taken[83:80], zero fill above
    output logic [87:0]  m_tdata,
    output logic         m_tlast,
    // write_valid[0]
    output logic         m_tuser
);
    import c6502_pkg::*;
    `include "cpu_6502_execute_unit_assert.svh"

    instr_t instr;
    regs_t  regs_reg;
    exec_t  res, res_reg;
    logic       valid_reg;
    logic [1:0] beat_reg;
    logic [1:0] nbeats;
    logic       final_beat;
    logic       s_fire;

    assign instr = '{func: s_tdata[5:0], addressing_class: s_tdata[7:6],
                     page_crossed: s_tdata[8], base_cycles: s_tdata[11:9],
                     operand_address: s_tdata[27:12], operand_value: s_tdata[35:28],
                     pc_after_fetch: s_tdata[51:36], stack_byte_first: s_tdata[59:52],
                     stack_byte_second: s_tdata[67:60], stack_byte_third: s_tdata[75:68],
                     break_vector: s_tdata[91:76]};

    c6502_alu u_alu (.instr(instr), .regs(regs_reg), .res(res));

    // Beat sequencing over the held result.
    assign nbeats = (res_reg.wr_count == 2'd0) ? 2'd1 : res_reg.wr_count;
    assign final_beat = (beat_reg == nbeats - 2'd1);
    assign s_tready = !valid_reg || (final_beat && m_tready);
    assign s_fire = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg  <= '{acc: 8'd0, x: 8'd0, y: 8'd0, sp: SP_RESET, flags: FLAG_RESET};
            valid_reg <= 1'b0;
            beat_reg  <= 2'd0;
        end else begin
            if (s_fire) begin
                regs_reg  <= res.regs;
                res_reg   <= res;
                valid_reg <= 1'b1;
                beat_reg  <= 2'd0;
            end else if (valid_reg && m_tready) begin
                if (final_beat) valid_reg <= 1'b0;
                else beat_reg <= beat_reg + 2'd1;
            end
        end
    end

    // Output beat.
    assign m_tvalid = valid_reg;
    assign m_tlast  = final_beat;
    assign m_tuser  = (res_reg.wr_count != 2'd0);
    assign m_tdata  = {4'd0, res_reg.cycles, res_reg.next_pc, res_reg.regs.flags,
                       res_reg.regs.sp, res_reg.regs.y, res_reg.regs.x, res_reg.regs.acc,
                       res_reg.wr_data[beat_reg], res_reg.wr_addr[beat_reg]};

    `ASSERT_IMPLY(a_beat_range, aclk, aresetn, valid_reg, beat_reg < nbeats,
                  "beat index beyond write count")
    `ASSERT_IMPLY(a_no_write_zero, aclk, aresetn, valid_reg && !m_tuser,
                  m_tdata[23:0] == 24'd0, "write fields not zero without a write")
    `ASSERT_NEXT(a_take_loads, aclk, aresetn, s_fire, valid_reg && beat_reg == 2'd0,
                 "accepted instruction not presented")
    `ASSERT_IMPLY(a_status_bits, aclk, aresetn, 1'b1,
                  regs_reg.flags[FL_U] && !regs_reg.flags[FL_B],
                  "status bits 5 and 4 wrong")
endmodule

>>> design/c6502_alu.sv
// Combinational execution of one instruction against the current registers.
module c6502_alu (
    input  c6502_pkg::instr_t instr,
    input  c6502_pkg::regs_t  regs,
    output c6502_pkg::exec_t  res
);
    import c6502_pkg::*;

    always_comb begin
        logic [7:0]  a, x, y, sp, f, m, v, cin;
        logic [8:0]  sum;
        logic [15:0] pc, npc, off, ret;
        logic [3:0]  cyc;
        logic        take, is_branch;
        logic [1:0]  n;
        logic [2:0][15:0] wa;
        logic [2:0][7:0]  wd;

        a = regs.acc; x = regs.x; y = regs.y; sp = regs.sp; f = regs.flags;
        m = instr.operand_value;
        pc = instr.pc_after_fetch;
        npc = pc;
        cyc = {1'b0, instr.base_cycles};
        n = 2'd0;
        wa = '0;
        wd = '0;
        v = '0;
        sum = '0;
        take = 1'b0;
        off = {{8{m[7]}}, m};
        ret = pc - 16'd1;
        cin = {7'd0, f[FL_C]};
        is_branch = 1'b0;

        // Branches.
        case (instr.func)
            F_BCC: begin is_branch = 1'b1; take = !f[FL_C]; end
            F_BCS: begin is_branch = 1'b1; take = f[FL_C]; end
            F_BEQ: begin is_branch = 1'b1; take = f[FL_Z]; end
            F_BMI: begin is_branch = 1'b1; take = f[FL_N]; end
            F_BNE: begin is_branch = 1'b1; take = !f[FL_Z]; end
            F_BPL: begin is_branch = 1'b1; take = !f[FL_N]; end
            F_BVC: begin is_branch = 1'b1; take = !f[FL_V]; end
            F_BVS: begin is_branch = 1'b1; take = f[FL_V]; end
            default: ;
        endcase
        if (is_branch && take) begin
            npc = pc + off;
            cyc = cyc + 4'd1;
            if (npc[15:8] != pc[15:8]) cyc = cyc + 4'd1;
        end

        // Everything else.
        case (instr.func)
            F_ADC, F_SBC: begin
                v = (instr.func == F_SBC) ? ~m : m;
                sum = {1'b0, a} + {1'b0, v} + {1'b0, cin};
                f[FL_C] = sum[8];
                f[FL_V] = ~(a[7] ^ v[7]) & (a[7] ^ sum[7]);
                a = sum[7:0];
                f[FL_Z] = (a == 8'd0); f[FL_N] = a[7];
            end
            F_AND, F_EOR, F_ORA: begin
                a = (instr.func == F_AND) ? (a & m) :
                    (instr.func == F_EOR) ? (a ^ m) : (a | m);
                f[FL_Z] = (a == 8'd0); f[FL_N] = a[7];
            end
            F_ASL, F_LSR, F_ROL, F_ROR: begin
                v = (instr.addressing_class == CLS_ACC) ? a : m;
                if (instr.func == F_ASL || instr.func == F_ROL) begin
                    f[FL_C] = v[7];
                    v = {v[6:0], (instr.func == F_ROL) ? cin[0] : 1'b0};
                end else begin
                    f[FL_C] = v[0];
                    v = {(instr.func == F_ROR) ? cin[0] : 1'b0, v[7:1]};
                end
                f[FL_Z] = (v == 8'd0); f[FL_N] = v[7];
                if (instr.addressing_class == CLS_ACC) a = v;
                else begin
                    n = 2'd1; wa[0] = instr.operand_address; wd[0] = v;
                end
            end
            F_BIT: begin
                f[FL_Z] = ((a & m) == 8'd0); f[FL_N] = m[7]; f[FL_V] = m[6];
            end
            F_BRK: begin
                n = 2'd3;
                wa[0] = {STACK_PAGE, sp};         wd[0] = pc[15:8];
                wa[1] = {STACK_PAGE, sp - 8'd1};  wd[1] = pc[7:0];
                wa[2] = {STACK_PAGE, sp - 8'd2};  wd[2] = f | 8'h30;
                sp = sp - 8'd3;
                f[FL_I] = 1'b1;
                npc = instr.break_vector;
            end
            F_CLC: f[FL_C] = 1'b0;
            F_CLD: f[FL_D] = 1'b0;
            F_CLI: f[FL_I] = 1'b0;
            F_CLV: f[FL_V] = 1'b0;
            F_SEC: f[FL_C] = 1'b1;
            F_SED: f[FL_D] = 1'b1;
            F_SEI: f[FL_I] = 1'b1;
            F_CMP, F_CPX, F_CPY: begin
                v = (instr.func == F_CMP) ? a : (instr.func == F_CPX) ? x : y;
                f[FL_C] = (v >= m);
                v = v - m;
                f[FL_Z] = (v == 8'd0); f[FL_N] = v[7];
            end
            F_DEC, F_INC: begin
                v = (instr.func == F_DEC) ? m - 8'd1 : m + 8'd1;
                n = 2'd1; wa[0] = instr.operand_address; wd[0] = v;
                f[FL_Z] = (v == 8'd0); f[FL_N] = v[7];
            end
            F_DEX: begin x = x - 8'd1; f[FL_Z] = (x == 8'd0); f[FL_N] = x[7]; end
            F_DEY: begin y = y - 8'd1; f[FL_Z] = (y == 8'd0); f[FL_N] = y[7]; end
            F_INX: begin x = x + 8'd1; f[FL_Z] = (x == 8'd0); f[FL_N] = x[7]; end
            F_INY: begin y = y + 8'd1; f[FL_Z] = (y == 8'd0); f[FL_N] = y[7]; end
            F_JMP: npc = instr.operand_address;
            F_JSR: begin
                n = 2'd2;
                wa[0] = {STACK_PAGE, sp};        wd[0] = ret[15:8];
                wa[1] = {STACK_PAGE, sp - 8'd1}; wd[1] = ret[7:0];
                sp = sp - 8'd2;
                npc = instr.operand_address;
            end
            F_LDA: begin a = m; f[FL_Z] = (m == 8'd0); f[FL_N] = m[7]; end
            F_LDX: begin x = m; f[FL_Z] = (m == 8'd0); f[FL_N] = m[7]; end
            F_LDY: begin y = m; f[FL_Z] = (m == 8'd0); f[FL_N] = m[7]; end
            F_PHA, F_PHP: begin
                n = 2'd1; wa[0] = {STACK_PAGE, sp};
                wd[0] = (instr.func == F_PHA) ? a : (f | 8'h30);
                sp = sp - 8'd1;
            end
            F_PLA: begin
                sp = sp + 8'd1; a = instr.stack_byte_first;
                f[FL_Z] = (a == 8'd0); f[FL_N] = a[7];
            end
            F_PLP: begin
                sp = sp + 8'd1; f = (instr.stack_byte_first & 8'hCF) | 8'h20;
            end
            F_RTI: begin
                sp = sp + 8'd3; f = (instr.stack_byte_first & 8'hCF) | 8'h20;
                npc = {instr.stack_byte_third, instr.stack_byte_second};
            end
            F_RTS: begin
                sp = sp + 8'd2;
                npc = {instr.stack_byte_second, instr.stack_byte_first} + 16'd1;
            end
            F_STA, F_STX, F_STY: begin
                n = 2'd1; wa[0] = instr.operand_address;
                wd[0] = (instr.func == F_STA) ? a : (instr.func == F_STX) ? x : y;
            end
            F_TAX: begin x = a; f[FL_Z] = (x == 8'd0); f[FL_N] = x[7]; end
            F_TAY: begin y = a; f[FL_Z] = (y == 8'd0); f[FL_N] = y[7]; end
            F_TSX: begin x = sp; f[FL_Z] = (x == 8'd0); f[FL_N] = x[7]; end
            F_TXA: begin a = x; f[FL_Z] = (a == 8'd0); f[FL_N] = a[7]; end
            F_TXS: sp = x;
            F_TYA: begin a = y; f[FL_Z] = (a == 8'd0); f[FL_N] = a[7]; end
            default: ;
        endcase

        // Page-crossing penalty.
        if (instr.page_crossed) begin
            if (instr.addressing_class == CLS_ABSX) begin
                case (instr.func)
                    F_ADC, F_AND, F_CMP, F_EOR, F_LDA, F_LDX, F_LDY, F_ORA, F_SBC:
                        cyc = cyc + 4'd1;
                    default: ;
                endcase
            end else if (instr.addressing_class == CLS_INDY &&
                         instr.func != F_STA) begin
                cyc = cyc + 4'd1;
            end
        end

        res.wr_count = n;
        res.wr_addr = wa;
        res.wr_data = wd;
        res.regs = '{acc: a, x: x, y: y, sp: sp, flags: f};
        res.next_pc = npc;
        res.cycles = cyc;
    end
endmodule
